// ===== rtl/ppr_pkg.sv =====
// shared types, codes and constants of the note priority pitch unit
package ppr_pkg;

  // event kinds
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_WHEEL    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROOT_NOTE  = 2'd0;
  localparam logic [1:0] REG_FINE_TUNE  = 2'd1;
  localparam logic [1:0] REG_BEND_RANGE = 2'd2;

  // priority encoder grouping
  localparam int GROUP_SIZE = 16;
  localparam int GROUP_BITS = 4;

  // pitch offset in units of 1/819200 semitone
  localparam int UNITS_PER_SEMI = 819200;
  localparam int UNITS_PER_CENT = 8192;
  localparam int BEND_SCALE     = 100;
  localparam int WHEEL_CENTRE   = 8192;
  localparam int OCT_BIAS       = 16;
  localparam int OCT_BIAS_UNITS = 157286400;
  localparam int UNIT_BITS      = 28;

  // one octave is 2^16 * 75 * 2 units
  localparam int          DIV_75    = 75;
  localparam logic [31:0] RECIP_75  = 32'd57266230;
  localparam logic [31:0] LN2_Q32   = 32'hB17217F7;
  localparam int          SERIES_TERMS = 12;

  typedef struct packed {
    logic       held;
    logic [6:0] top;
    logic       trig;
  } ppr_tag_t;

  typedef struct packed {
    ppr_tag_t    tag;
    logic [4:0]  octave;
    logic [31:0] frac_y;
    logic [31:0] term;
    logic [32:0] sum;
  } ppr_ser_t;

  // floor(2^32 / k) for the series divisors
  function automatic logic [31:0] ppr_recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ppr_notes.sv =====
// held note map, wheel position and two-level highest note encoder
module ppr_notes #(
  parameter int NOTE_COUNT = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        en,
  input  logic [1:0]        operation,
  input  logic [6:0]        note_number,
  input  logic [13:0]       wheel_value,
  output ppr_pkg::ppr_tag_t tag,
  output logic [13:0]       wheel
);
  import ppr_pkg::*;

  localparam int GROUPS   = (NOTE_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int MAP_BITS = GROUPS * GROUP_SIZE;

  logic [NOTE_COUNT-1:0] held;
  logic [NOTE_COUNT-1:0] held_next;
  logic [13:0]           wheel_pos;
  logic [13:0]           wheel_pos_next;
  logic                  trig_next;
  logic                  note_ok;
  logic [MAP_BITS-1:0]   map_pad;
  logic [GROUPS-1:0]     grp_any_next;
  logic [GROUP_BITS-1:0] grp_idx_next [GROUPS];

  logic [GROUPS-1:0]     grp_any;
  logic [GROUP_BITS-1:0] grp_idx [GROUPS];
  logic                  trig_s1;
  logic [13:0]           wheel_s1;
  logic [6:0]            top_next;

  assign note_ok = ({1'b0, note_number} < 8'(NOTE_COUNT));

  always_comb begin
    held_next      = held;
    wheel_pos_next = wheel_pos;
    trig_next      = 1'b0;
    if (accept) begin
      unique case (operation)
        OP_NOTE_ON: begin
          for (int i = 0; i < NOTE_COUNT; i++) begin
            if (note_number == 7'(i)) held_next[i] = 1'b1;
          end
          trig_next = note_ok;
        end
        OP_NOTE_OFF: begin
          for (int i = 0; i < NOTE_COUNT; i++) begin
            if (note_number == 7'(i)) held_next[i] = 1'b0;
          end
        end
        OP_WHEEL: wheel_pos_next = wheel_value;
        default: ;
      endcase
    end
  end

  // first level: highest set bit inside each group of sixteen
  always_comb begin
    map_pad = '0;
    map_pad[NOTE_COUNT-1:0] = held_next;
    for (int g = 0; g < GROUPS; g++) begin
      grp_any_next[g] = |map_pad[g*GROUP_SIZE +: GROUP_SIZE];
      grp_idx_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (map_pad[g*GROUP_SIZE + j]) grp_idx_next[g] = GROUP_BITS'(j);
      end
    end
  end

  // second level: highest group wins
  always_comb begin
    top_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (grp_any[g]) top_next = 7'((g << GROUP_BITS) + int'(grp_idx[g]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      wheel_pos <= 14'(WHEEL_CENTRE);
    end else begin
      held      <= held_next;
      wheel_pos <= wheel_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      grp_any  <= grp_any_next;
      grp_idx  <= grp_idx_next;
      trig_s1  <= trig_next;
      wheel_s1 <= wheel_pos_next;
    end
    if (en[1]) begin
      tag.held <= |grp_any;
      tag.top  <= top_next;
      tag.trig <= trig_s1;
      wheel    <= wheel_s1;
    end
  end

endmodule

// ===== rtl/ppr_octave.sv =====
// pitch offset, split into octave and fraction, fraction times ln2
module ppr_octave (
  input  logic              clk,
  input  logic [5:0]        en,
  input  ppr_pkg::ppr_tag_t tag_in,
  input  logic [13:0]       wheel,
  input  logic [6:0]        root_note,
  input  logic signed [6:0] fine_tune_cents,
  input  logic [2:0]        bend_range,
  output ppr_pkg::ppr_ser_t ser
);
  import ppr_pkg::*;

  logic signed [8:0]  note_diff;
  logic signed [14:0] wheel_off;
  logic signed [18:0] bend_off;
  logic signed [31:0] u_full;

  ppr_tag_t               tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
  logic [UNIT_BITS-1:0]   u_s3, u_s4;
  logic [59:0]            prod1;
  logic [21:0]            a0;
  logic [UNIT_BITS-1:0]   a0_x;
  logic [UNIT_BITS-1:0]   r0;
  logic [21:0]            a_s5, a_s6;
  logic [6:0]             b_s5, b_s6;
  logic [53:0]            prod2;
  logic [21:0]            v6;
  logic [14:0]            g0;
  logic [21:0]            rg;
  logic [14:0]            g;
  logic [4:0]             oct_s7;
  logic [31:0]            frac_s7;
  logic [63:0]            y_prod;

  assign note_diff = signed'({2'b00, tag_in.top}) - signed'({2'b00, root_note});
  assign wheel_off = signed'({1'b0, wheel}) - 15'sd8192;
  assign bend_off  = 19'(wheel_off) * 19'(signed'({1'b0, bend_range}));
  assign u_full    = 32'(note_diff) * UNITS_PER_SEMI
                   + 32'(fine_tune_cents) * UNITS_PER_CENT
                   + 32'(bend_off) * BEND_SCALE
                   + OCT_BIAS_UNITS;

  // u = 75a + b, reciprocal estimate is low by at most one
  assign a0   = prod1[53:32];
  assign a0_x = UNIT_BITS'({6'b0, a0} * 28'd75);
  assign r0   = u_s4 - a0_x;

  // g = floor(b * 2^15 / 75)
  assign v6 = {b_s6, 15'b0};
  assign g0 = prod2[46:32];
  assign rg = v6 - 22'({7'b0, g0} * 22'd75);
  assign g  = (rg[7:0] >= 8'(DIV_75)) ? g0 + 15'd1 : g0;

  assign y_prod = {32'b0, frac_s7} * {32'b0, LN2_Q32};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag_s3 <= tag_in;
      u_s3   <= u_full[UNIT_BITS-1:0];
    end
    if (en[1]) begin
      tag_s4 <= tag_s3;
      u_s4   <= u_s3;
      prod1  <= {32'b0, u_s3} * {28'b0, RECIP_75};
    end
    if (en[2]) begin
      tag_s5 <= tag_s4;
      if (r0[7:0] >= 8'(DIV_75)) begin
        a_s5 <= a0 + 22'd1;
        b_s5 <= 7'(r0[7:0] - 8'(DIV_75));
      end else begin
        a_s5 <= a0;
        b_s5 <= r0[6:0];
      end
    end
    if (en[3]) begin
      tag_s6 <= tag_s5;
      a_s6   <= a_s5;
      b_s6   <= b_s5;
      prod2  <= {32'b0, b_s5, 15'b0} * {22'b0, RECIP_75};
    end
    if (en[4]) begin
      tag_s7  <= tag_s6;
      oct_s7  <= a_s6[21:17];
      frac_s7 <= {a_s6[16:0], g};
    end
    if (en[5]) begin
      ser.tag    <= tag_s7;
      ser.octave <= oct_s7;
      ser.frac_y <= y_prod[63:32];
      ser.term   <= y_prod[63:32];
      ser.sum    <= {1'b1, y_prod[63:32]};
    end
  end

endmodule

// ===== rtl/ppr_term.sv =====
// one exponential series term: multiply by y, divide by k, accumulate
module ppr_term (
  input  logic              clk,
  input  logic [2:0]        en,
  input  logic [3:0]        divisor,
  input  ppr_pkg::ppr_ser_t ser_in,
  output ppr_pkg::ppr_ser_t ser_out
);
  import ppr_pkg::*;

  ppr_ser_t    ser_a, ser_b;
  ppr_ser_t    ser_a_next;
  ppr_ser_t    ser_out_next;
  logic [63:0] hi_prod;
  logic [63:0] pm;
  logic [31:0] q0;
  logic [31:0] rq;
  logic [31:0] q;

  assign hi_prod = {32'b0, ser_in.term} * {32'b0, ser_in.frac_y};
  assign q0      = pm[63:32];
  assign rq      = ser_b.term - 32'(q0 * {28'b0, divisor});
  assign q       = (rq >= {28'b0, divisor}) ? q0 + 32'd1 : q0;

  always_comb begin
    ser_a_next      = ser_in;
    ser_a_next.term = hi_prod[63:32];
  end

  always_comb begin
    ser_out_next      = ser_b;
    ser_out_next.term = q;
    ser_out_next.sum  = ser_b.sum + {1'b0, q};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ser_a <= ser_a_next;
    end
    if (en[1]) begin
      ser_b <= ser_a;
      pm    <= {32'b0, ser_a.term} * {32'b0, ppr_recip(divisor)};
    end
    if (en[2]) begin
      ser_out <= ser_out_next;
    end
  end

endmodule

// ===== rtl/midi_note_priority_pitch.sv =====
// top level: note priority pitch unit, stage control, registers and output
//
// Events enter on the event channel (operation, note_number, wheel_value),
// one beat per event; every event gives exactly one result beat on the
// result channel (note_held, top_note, pitch_ratio, trigger_grain).
// Configuration (root note, fine tune, bend range) is written through
// cfg_write / cfg_index / cfg_data; the user must do so only while no event
// is in flight, which the block itself does not enforce. The held note map
// and wheel position change as the event is taken; the ratio is worked out
// in a 42-stage pipeline: note map encoder (2), octave and fraction split
// with two reciprocal multiplies (6), and eleven series terms of 3 stages
// each, then the rounding shift and output stage. One event per cycle is
// taken while event_stall is low.
// When result_stall is high, the result holds and the stages below still
// close up empty slots; event_stall rises only once every stage is full.
// Reset empties the pipeline, clears all held notes, centres the wheel,
// sets the kept ratio to unity and loads the default configuration.
module midi_note_priority_pitch #(
  parameter int NOTE_COUNT      = 128,
  parameter int RATIO_FRAC_BITS = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        event_valid,
  output logic        event_stall,
  input  logic [1:0]  operation,
  input  logic [6:0]  note_number,
  input  logic [13:0] wheel_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        note_held,
  output logic [6:0]  top_note,
  output logic [31:0] pitch_ratio,
  output logic        trigger_grain,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import ppr_pkg::*;

  localparam int NOTE_STAGES = 2;
  localparam int OCT_STAGES  = 6;
  localparam int TERM_STAGES = 3;
  localparam int ST_OCT      = NOTE_STAGES;
  localparam int ST_SERIES   = ST_OCT + OCT_STAGES;
  localparam int ST_OUT      = ST_SERIES + TERM_STAGES * (SERIES_TERMS - 1);
  localparam int NSTAGE      = ST_OUT + 1;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;
  logic              accept;

  logic [6:0]        root_note;
  logic signed [6:0] fine_tune_cents;
  logic [2:0]        bend_range;

  ppr_tag_t    tag_n;
  logic [13:0] wheel_n;
  ppr_ser_t    ser_chain [1:SERIES_TERMS];

  logic signed [7:0] sh;
  logic [5:0]        r;
  logic [63:0]       rounded;
  logic [31:0]       ratio;
  logic [31:0]       last_ratio;

  // a stage may load when the result is not stalled, or when it or any stage after it holds a gap
  for (genvar i = 0; i < NSTAGE; i++) begin : g_en
    assign en[i] = ~(&v[NSTAGE-1:i]) | ~result_stall;
  end

  assign accept       = event_valid & en[0];
  assign event_stall  = ~en[0];
  assign result_valid = v[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= accept;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_note       <= 7'd60;
      fine_tune_cents <= 7'sd0;
      bend_range      <= 3'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROOT_NOTE:  root_note       <= cfg_data;
        REG_FINE_TUNE:  fine_tune_cents <= signed'(cfg_data);
        REG_BEND_RANGE: bend_range      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  ppr_notes #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_notes (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .en          (en[0 +: NOTE_STAGES]),
    .operation   (operation),
    .note_number (note_number),
    .wheel_value (wheel_value),
    .tag         (tag_n),
    .wheel       (wheel_n)
  );

  ppr_octave u_octave (
    .clk             (clk),
    .en              (en[ST_OCT +: OCT_STAGES]),
    .tag_in          (tag_n),
    .wheel           (wheel_n),
    .root_note       (root_note),
    .fine_tune_cents (fine_tune_cents),
    .bend_range      (bend_range),
    .ser             (ser_chain[1])
  );

  for (genvar k = 2; k <= SERIES_TERMS; k++) begin : g_term
    ppr_term u_term (
      .clk     (clk),
      .en      (en[ST_SERIES + TERM_STAGES*(k-2) +: TERM_STAGES]),
      .divisor (4'(k)),
      .ser_in  (ser_chain[k-1]),
      .ser_out (ser_chain[k])
    );
  end

  // scale 2^(octave-16) * sum to the output format, round half up
  assign sh      = 8'sd48 - 8'(RATIO_FRAC_BITS) - signed'({3'b000, ser_chain[SERIES_TERMS].octave});
  assign r       = sh[5:0];
  assign rounded = ({31'b0, ser_chain[SERIES_TERMS].sum} + (64'd1 << 6'(r - 6'd1))) >> r;

  always_comb begin
    if (sh <= 8'sd0) begin
      ratio = '1;
    end else if (|rounded[63:32]) begin
      ratio = '1;
    end else begin
      ratio = rounded[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ratio <= 32'd1 << RATIO_FRAC_BITS;
    end else if (en[ST_OUT] && v[ST_OUT-1] && ser_chain[SERIES_TERMS].tag.held) begin
      last_ratio <= ratio;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      note_held     <= ser_chain[SERIES_TERMS].tag.held;
      top_note      <= ser_chain[SERIES_TERMS].tag.top;
      trigger_grain <= ser_chain[SERIES_TERMS].tag.trig;
      pitch_ratio   <= ser_chain[SERIES_TERMS].tag.held ? ratio : last_ratio;
    end
  end

endmodule
